// ===== rtl/efpsa_pkg.sv =====
// Shared types and constants for the exact float partial-sum accumulator.
`default_nettype none
package efpsa_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] total;
    logic [6:0]  partial_count;
    logic        overflowed;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_DAT,
    S_A_HI,
    S_A_T,
    S_A_LO,
    S_A_APP,
    S_SH_RD,
    S_SH_WR,
    S_SH_FIN,
    S_R_RD,
    S_R_DAT,
    S_R_X,
    S_R_Y,
    S_R_T,
    S_R_C,
    S_R_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/efpsa_mem.sv =====
// Partial-sum storage: one write port, one read port with registered data.
`default_nettype none
module efpsa_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/efpsa_fadd.sv =====
// Four-stage binary64 adder/subtractor, round to nearest even.
`default_nettype none
module efpsa_fadd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic        sub,
  output logic             done,
  output logic      [63:0] res
);

  function automatic logic [5:0] clz56(input logic [55:0] v);
    logic [5:0] n;
    n = 6'd56;
    for (int k = 0; k < 56; k++) begin
      if (v[k]) n = 6'(55 - k);
    end
    return n;
  endfunction

  // stage 1: specials, order, align
  logic [63:0]  bn;
  logic         a_nan, b_nan, a_inf, b_inf;
  logic         spec;
  logic [63:0]  spec_val;
  logic         swap;
  logic [63:0]  lg, sm;
  logic [10:0]  el, es;
  logic [55:0]  ml, ms;
  logic [10:0]  d;
  logic [6:0]   dc;
  logic [119:0] shv;
  logic [55:0]  ms_al;

  always_comb begin
    bn    = {b[63] ^ sub, b[62:0]};
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == '0);
    b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
    spec  = a_nan || b_nan || a_inf || b_inf;
    if (a_nan) begin
      spec_val = a | 64'h0008_0000_0000_0000;
    end else if (b_nan) begin
      spec_val = b | 64'h0008_0000_0000_0000;
    end else if (a_inf && b_inf && (a[63] != bn[63])) begin
      spec_val = 64'hFFF8_0000_0000_0000;
    end else if (a_inf) begin
      spec_val = a;
    end else begin
      spec_val = bn;
    end
    swap  = bn[62:0] > a[62:0];
    lg    = swap ? bn : a;
    sm    = swap ? a : bn;
    el    = (lg[62:52] == '0) ? 11'd1 : lg[62:52];
    es    = (sm[62:52] == '0) ? 11'd1 : sm[62:52];
    ml    = {(lg[62:52] != '0), lg[51:0], 3'b000};
    ms    = {(sm[62:52] != '0), sm[51:0], 3'b000};
    d     = el - es;
    dc    = (d > 11'd64) ? 7'd64 : d[6:0];
    shv   = {ms, 64'b0} >> dc;
    ms_al = {shv[119:65], shv[64] | (shv[63:0] != '0)};
  end

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        spec1_r, spec2_r, spec3_r;
  logic [63:0] sval1_r, sval2_r, sval3_r;
  logic        sgn1_r, sgn2_r, sgn3_r;
  logic        esub1_r, esub2_r, esub3_r;
  logic [10:0] el1_r, el2_r;
  logic [55:0] ml1_r, ms1_r;
  logic [56:0] sum2_r;
  logic [55:0] m3_r;
  logic [11:0] e3_r;
  logic        zero3_r;
  logic [63:0] res_r;

  // stage 2 / 3 logic
  logic [56:0] sum_nxt;
  logic [5:0]  lz;
  logic [10:0] lim;
  logic [10:0] shamt;
  logic [55:0] m_nxt;
  logic [11:0] e_nxt;

  always_comb begin
    sum_nxt = esub1_r ? ({1'b0, ml1_r} - {1'b0, ms1_r}) : ({1'b0, ml1_r} + {1'b0, ms1_r});
    lz      = clz56(sum2_r[55:0]);
    lim     = el2_r - 11'd1;
    shamt   = ({5'b0, lz} < lim) ? {5'b0, lz} : lim;
    if (sum2_r[56]) begin
      m_nxt = {sum2_r[56:2], sum2_r[1] | sum2_r[0]};
      e_nxt = {1'b0, el2_r} + 12'd1;
    end else begin
      m_nxt = sum2_r[55:0] << shamt[5:0];
      e_nxt = {1'b0, el2_r} - {1'b0, shamt};
    end
  end

  // stage 4: round and pack
  logic [11:0] fe, fe2;
  logic [53:0] rnd;
  logic        inc;
  logic [51:0] frac;
  logic [63:0] res_nxt;

  always_comb begin
    fe  = m3_r[55] ? e3_r : 12'd0;
    inc = m3_r[2] & (m3_r[1] | m3_r[0] | m3_r[3]);
    rnd = {1'b0, m3_r[55:3]} + {53'b0, inc};
    if (rnd[53]) begin
      fe2  = fe + 12'd1;
      frac = rnd[52:1];
    end else if ((fe == '0) && rnd[52]) begin
      fe2  = 12'd1;
      frac = rnd[51:0];
    end else begin
      fe2  = fe;
      frac = rnd[51:0];
    end
    if (spec3_r) begin
      res_nxt = sval3_r;
    end else if (zero3_r) begin
      res_nxt = {sgn3_r & ~esub3_r, 63'b0};
    end else if (fe2 >= 12'd2047) begin
      res_nxt = {sgn3_r, 11'h7FF, 52'b0};
    end else begin
      res_nxt = {sgn3_r, fe2[10:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    spec1_r <= spec;
    sval1_r <= spec_val;
    sgn1_r  <= lg[63];
    esub1_r <= lg[63] ^ sm[63];
    el1_r   <= el;
    ml1_r   <= ml;
    ms1_r   <= ms_al;
    spec2_r <= spec1_r;
    sval2_r <= sval1_r;
    sgn2_r  <= sgn1_r;
    esub2_r <= esub1_r;
    el2_r   <= el1_r;
    sum2_r  <= sum_nxt;
    spec3_r <= spec2_r;
    sval3_r <= sval2_r;
    sgn3_r  <= sgn2_r;
    esub3_r <= esub2_r;
    m3_r    <= m_nxt;
    e3_r    <= e_nxt;
    zero3_r <= (sum2_r == '0);
    res_r   <= res_nxt;
  end

  assign done = v4_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// ===== rtl/exact_float_partial_sum_accumulator.sv =====
// Exact binary64 accumulator: a list of non-overlapping partials in one memory,
// updated by a walk of two-sums; reads return a Kahan sum of the list.
//
// Commands: add folds the value into the partials, read returns one result
// (total, partial count, sticky overflow), clear empties the list. One item is
// worked at a time. Every floating-point step goes through one shared
// adder, and the list sits in a single memory with a registered read.
// An add walks every held partial (read, compare, then three dependent adds
// for the two-sum per entry); when the list overflows and the lowest entry is
// dropped, a shift sweep moves the upper entries down. A read makes four
// dependent adds per entry. Clear is handled in the idle state. The result
// sits in an output register, so input transfers continue while it waits; a
// second read stalls only at its own result.
`default_nettype none
module exact_float_partial_sum_accumulator #(
  parameter int MAX_PARTIALS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire efpsa_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output efpsa_pkg::out_item_t      out_data
);

  localparam int IW = $clog2(MAX_PARTIALS);
  localparam int CW = $clog2(MAX_PARTIALS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PARTIALS);
  localparam logic [CW-1:0] LASTM = CW'(MAX_PARTIALS - 2);

  efpsa_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic [63:0]   x_r, x_nxt;       // running value / new Kahan sum
  logic [63:0]   big_r, big_nxt;   // larger operand / Kahan y
  logic [63:0]   small_r, small_nxt; // smaller operand / partial read
  logic [63:0]   t_r, t_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   comp_r, comp_nxt;
  logic          fbusy_r, fbusy_nxt;
  logic          out_valid_r, out_valid_nxt;
  efpsa_pkg::out_item_t out_r, out_nxt;

  // memory ports
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  // adder ports
  logic          fa_start, fa_sub, fa_done;
  logic [63:0]   fa_a, fa_b, fa_res;

  efpsa_mem #(.DEPTH(MAX_PARTIALS), .AW(IW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  efpsa_fadd u_fadd (
    .clk  (clk),
    .rst_n(rst_n),
    .start(fa_start),
    .a    (fa_a),
    .b    (fa_b),
    .sub  (fa_sub),
    .done (fa_done),
    .res  (fa_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efpsa_pkg::S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      fbusy_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      fbusy_r     <= fbusy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    x_r     <= x_nxt;
    big_r   <= big_nxt;
    small_r <= small_nxt;
    t_r     <= t_nxt;
    acc_r   <= acc_nxt;
    comp_r  <= comp_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    x_nxt         = x_r;
    big_nxt       = big_r;
    small_nxt     = small_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    comp_nxt      = comp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    we            = 1'b0;
    waddr         = n_r[IW-1:0];
    wdata         = x_r;
    raddr         = i_r[IW-1:0];
    fa_a          = big_r;
    fa_b          = small_r;
    fa_sub        = 1'b0;
    fa_start      = 1'b0;

    // the adder op states share one start/finish handshake
    if ((state_r == efpsa_pkg::S_A_HI) || (state_r == efpsa_pkg::S_A_T) ||
        (state_r == efpsa_pkg::S_A_LO) || (state_r == efpsa_pkg::S_R_X) ||
        (state_r == efpsa_pkg::S_R_Y) || (state_r == efpsa_pkg::S_R_T) ||
        (state_r == efpsa_pkg::S_R_C)) begin
      fa_start = !fbusy_r;
    end
    fbusy_nxt = (fbusy_r || fa_start) && !fa_done;

    case (state_r)
      efpsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.command)
            efpsa_pkg::CMD_ADD: begin
              x_nxt     = in_data.value;
              i_nxt     = '0;
              n_nxt     = '0;
              state_nxt = (cnt_r == '0) ? efpsa_pkg::S_A_APP : efpsa_pkg::S_A_RD;
            end
            efpsa_pkg::CMD_READ: begin
              acc_nxt   = '0;
              comp_nxt  = '0;
              i_nxt     = cnt_r;
              state_nxt = (cnt_r == '0) ? efpsa_pkg::S_R_OUT : efpsa_pkg::S_R_RD;
            end
            efpsa_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      efpsa_pkg::S_A_RD: begin
        state_nxt = efpsa_pkg::S_A_DAT;
      end
      efpsa_pkg::S_A_DAT: begin
        // larger magnitude goes first in the two-sum; a NaN partial never counts as larger
        if ((x_r[62:0] < rdata[62:0]) &&
            (rdata[62:0] <= 63'h7FF0_0000_0000_0000)) begin
          big_nxt   = rdata;
          small_nxt = x_r;
        end else begin
          big_nxt   = x_r;
          small_nxt = rdata;
        end
        state_nxt = efpsa_pkg::S_A_HI;
      end
      efpsa_pkg::S_A_HI: begin
        if (fa_done) begin
          x_nxt     = fa_res;
          state_nxt = efpsa_pkg::S_A_T;
        end
      end
      efpsa_pkg::S_A_T: begin
        fa_a   = x_r;
        fa_b   = big_r;
        fa_sub = 1'b1;
        if (fa_done) begin
          t_nxt     = fa_res;
          state_nxt = efpsa_pkg::S_A_LO;
        end
      end
      efpsa_pkg::S_A_LO: begin
        fa_a   = small_r;
        fa_b   = t_r;
        fa_sub = 1'b1;
        wdata  = fa_res;
        if (fa_done) begin
          if (fa_res[62:0] != '0) begin
            we    = 1'b1;
            n_nxt = n_r + 1'b1;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = ((i_r + 1'b1) == cnt_r) ? efpsa_pkg::S_A_APP : efpsa_pkg::S_A_RD;
        end
      end
      efpsa_pkg::S_A_APP: begin
        if (n_r == MAXC) begin
          // list is one over capacity: drop entry 0 by shifting down
          i_nxt     = '0;
          state_nxt = efpsa_pkg::S_SH_RD;
        end else begin
          we        = 1'b1;
          cnt_nxt   = n_r + 1'b1;
          state_nxt = efpsa_pkg::S_IDLE;
        end
      end
      efpsa_pkg::S_SH_RD: begin
        raddr     = IW'(i_r + 1'b1);
        state_nxt = efpsa_pkg::S_SH_WR;
      end
      efpsa_pkg::S_SH_WR: begin
        we    = 1'b1;
        waddr = i_r[IW-1:0];
        wdata = rdata;
        if (i_r == LASTM) begin
          state_nxt = efpsa_pkg::S_SH_FIN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = efpsa_pkg::S_SH_RD;
        end
      end
      efpsa_pkg::S_SH_FIN: begin
        we        = 1'b1;
        waddr     = IW'(MAX_PARTIALS - 1);
        cnt_nxt   = MAXC;
        ovf_nxt   = 1'b1;
        state_nxt = efpsa_pkg::S_IDLE;
      end
      efpsa_pkg::S_R_RD: begin
        raddr     = IW'(i_r - 1'b1);
        i_nxt     = i_r - 1'b1;
        state_nxt = efpsa_pkg::S_R_DAT;
      end
      efpsa_pkg::S_R_DAT: begin
        small_nxt = rdata;
        state_nxt = efpsa_pkg::S_R_X;
      end
      efpsa_pkg::S_R_X: begin
        fa_a   = small_r;
        fa_b   = comp_r;
        fa_sub = 1'b1;
        if (fa_done) begin
          big_nxt   = fa_res;
          state_nxt = efpsa_pkg::S_R_Y;
        end
      end
      efpsa_pkg::S_R_Y: begin
        fa_a = acc_r;
        fa_b = big_r;
        if (fa_done) begin
          x_nxt     = fa_res;
          state_nxt = efpsa_pkg::S_R_T;
        end
      end
      efpsa_pkg::S_R_T: begin
        fa_a   = x_r;
        fa_b   = acc_r;
        fa_sub = 1'b1;
        if (fa_done) begin
          t_nxt     = fa_res;
          state_nxt = efpsa_pkg::S_R_C;
        end
      end
      efpsa_pkg::S_R_C: begin
        fa_a   = t_r;
        fa_b   = big_r;
        fa_sub = 1'b1;
        if (fa_done) begin
          comp_nxt  = fa_res;
          acc_nxt   = x_r;
          state_nxt = (i_r == '0) ? efpsa_pkg::S_R_OUT : efpsa_pkg::S_R_RD;
        end
      end
      efpsa_pkg::S_R_OUT: begin
        // wait for the output register to drain
        if (!out_valid_r) begin
          out_nxt.total         = acc_r;
          out_nxt.partial_count = 7'(cnt_r);
          out_nxt.overflowed    = ovf_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = efpsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = efpsa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fa_done |-> fbusy_r)
    else $error("adder finished with no operation pending");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXC)
    else $error("partial count above capacity");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == efpsa_pkg::S_R_OUT) && !out_valid_r |=> out_valid_r)
    else $error("read result not loaded");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

endmodule
`default_nettype wire
